### rtl/core/cstm_pkg.sv
// Shared types, constants and helpers for the charging statistics monitor.
package cstm_pkg;

  localparam int TEMP_W     = 12;
  localparam int CAP_W      = 16;
  localparam int MV_W       = 16;
  localparam int RUN_W      = 8;
  localparam int ALGO_W     = 8;
  localparam int CNT_W      = 31;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SENS_N     = 4;
  localparam int ROW_N      = 4;
  localparam int ROW_AW     = $clog2(ROW_N);
  localparam int SUB_W      = $clog2(2 * SENS_N);
  localparam int OUTQ_DEPTH = 4;
  localparam int QAW        = $clog2(OUTQ_DEPTH);
  localparam int PEND_W     = QAW + 1;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [2*SENS_N-1:0][TEMP_W-1:0] temp_row_t;

  localparam temp_t TEMP_MAX_RESET = -12'sd300;
  localparam temp_t TEMP_MIN_RESET = 12'sd1000;
  localparam logic [CAP_W-1:0] CAP_MIN_RESET = 16'hFFFF;
  localparam logic [CNT_W-1:0] CNT_LIMIT     = 31'h7FFF_FFFF;
  localparam logic [RUN_W-1:0] RUN_LIMIT     = 8'hFF;

  localparam logic [MV_W-1:0]   OV_MV_RESET      = 16'd4400;
  localparam logic [RUN_W-1:0]  OV_SAMPLES_RESET = 8'd2;
  localparam temp_t             HEAT_LIMIT_RESET = 12'sd800;
  localparam logic [ALGO_W-1:0] ALGO_RESET       = 8'd0;

  localparam logic [CFG_IDX_W-1:0] REG_OV_MV      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OV_SAMPLES = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_LIMIT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALGO       = 4'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] ST_CHARGING     = 2'd0;
  localparam logic [1:0] ST_FULL         = 2'd1;
  localparam logic [1:0] ST_NOT_CHARGING = 2'd2;
  localparam logic [1:0] ST_DISCHARGING  = 2'd3;

  localparam logic [1:0] GF_GOOD      = 2'd0;
  localparam logic [1:0] GF_FULL_FAIL = 2'd1;
  localparam logic [1:0] GF_AGED_FAIL = 2'd2;
  localparam logic [1:0] GF_BOTH_FAIL = 2'd3;

  localparam logic [IDX_W-1:0] STAT_ALGO       = 6'd0;
  localparam logic [IDX_W-1:0] STAT_TEMP_FIRST = 6'd1;
  localparam logic [IDX_W-1:0] STAT_TEMP_LAST  = 6'd32;
  localparam logic [IDX_W-1:0] STAT_CAP_MAX    = 6'd33;
  localparam logic [IDX_W-1:0] STAT_CAP_MIN    = 6'd34;
  localparam logic [IDX_W-1:0] STAT_CAP_MAX_D  = 6'd35;
  localparam logic [IDX_W-1:0] STAT_CAP_MIN_D  = 6'd36;
  localparam logic [IDX_W-1:0] STAT_NOMINAL    = 6'd37;
  localparam logic [IDX_W-1:0] STAT_OVP_CNT    = 6'd38;
  localparam logic [IDX_W-1:0] STAT_OVP_CNT_D  = 6'd39;
  localparam logic [IDX_W-1:0] STAT_HEAT_CNT   = 6'd40;
  localparam logic [IDX_W-1:0] STAT_HEAT_CNT_D = 6'd41;
  localparam logic [IDX_W-1:0] STAT_OV_RUN     = 6'd42;
  localparam logic [IDX_W-1:0] STAT_OVP_FLAG   = 6'd43;
  localparam logic [IDX_W-1:0] STAT_HEAT_FLAG  = 6'd44;

  localparam int CNT_OVP      = 0;
  localparam int CNT_OVP_DAY  = 1;
  localparam int CNT_HEAT     = 2;
  localparam int CNT_HEAT_DAY = 3;

  typedef struct packed {
    logic              operation;
    logic              skip;
    logic [1:0]        charge_status;
    logic [MV_W-1:0]   voltage_mv;
    temp_t             battery_temp;
    temp_t             charger_temp;
    temp_t             wireless_temp;
    temp_t             conn_temp;
    logic [CAP_W-1:0]  full_capacity;
    logic [CAP_W-1:0]  aged_capacity;
    logic [1:0]        gauge_fail;
    logic [IDX_W-1:0]  stat_index;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    ovp_tripped;
    logic                    ovp_latched;
    logic                    overheat_counted;
    logic                    sample_skipped;
  } out_item_t;

  typedef struct packed {
    logic                     is_read;
    logic                     rd_temp;
    logic [ROW_N-1:0]         grp_en;
    logic [ROW_AW-1:0]        rd_row;
    logic [SUB_W-1:0]         rd_sub;
    logic [SENS_N-1:0][TEMP_W-1:0] temps;
    out_item_t                res;
  } job_t;

  function automatic temp_row_t reset_row();
    temp_row_t r;
    for (int i = 0; i < 2 * SENS_N; i++) begin
      r[i] = (i % 2 == 1) ? TEMP_MIN_RESET : TEMP_MAX_RESET;
    end
    return r;
  endfunction

endpackage

### rtl/core/cstm_ifs.sv
// Valid/ready channel interfaces for sample, result and configuration transfers.
interface cstm_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic               skip;
  logic [1:0]         charge_status;
  logic [15:0]        voltage_mv;
  logic signed [11:0] battery_temp;
  logic signed [11:0] charger_temp;
  logic signed [11:0] wireless_temp;
  logic signed [11:0] conn_temp;
  logic [15:0]        full_capacity;
  logic [15:0]        aged_capacity;
  logic [1:0]         gauge_fail;
  logic [5:0]         stat_index;

  modport source (
    output valid, operation, skip, charge_status, voltage_mv, battery_temp,
           charger_temp, wireless_temp, conn_temp, full_capacity, aged_capacity,
           gauge_fail, stat_index,
    input  ready
  );
  modport sink (
    input  valid, operation, skip, charge_status, voltage_mv, battery_temp,
           charger_temp, wireless_temp, conn_temp, full_capacity, aged_capacity,
           gauge_fail, stat_index,
    output ready
  );
endinterface

interface cstm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               ovp_tripped;
  logic               ovp_latched;
  logic               overheat_counted;
  logic               sample_skipped;

  modport source (
    output valid, read_value, ovp_tripped, ovp_latched, overheat_counted, sample_skipped,
    input  ready
  );
  modport sink (
    input  valid, read_value, ovp_tripped, ovp_latched, overheat_counted, sample_skipped,
    output ready
  );
endinterface

interface cstm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

### rtl/core/cstm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cstm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/cstm_scalars.sv
// Configuration registers, scalar statistics, debounce and per-item job decode.
module cstm_scalars (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  cstm_pkg::in_item_t                item,
  input  logic                              cfg_we,
  input  logic [cstm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [cstm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cstm_pkg::job_t                    job
);
  import cstm_pkg::*;

  logic [MV_W-1:0]   ov_mv_r;
  logic [RUN_W-1:0]  ov_samples_r;
  temp_t             heat_limit_r;
  logic [ALGO_W-1:0] algo_r;
  logic [CAP_W-1:0]  cap_r [4];
  logic [CAP_W-1:0]  cap_nxt [4];
  logic [CAP_W-1:0]  nominal_r, nominal_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic              ovp_flag_r, ovp_flag_nxt;
  logic              heat_flag_r, heat_flag_nxt;
  logic [CNT_W-1:0]  cnt_r [4];
  logic [CNT_W-1:0]  cnt_nxt [4];

  logic charging, check_v, sample, trip, heat, full_fail, aged_fail, skipped_s;
  logic [RUN_W-1:0] run_calc;
  logic [IDX_W-1:0] idx_m1;
  logic [VAL_W-1:0] stat_value;
  logic [CAP_W-1:0] cap_full;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_LIMIT) ? v : v + 31'd1;
  endfunction

  always_comb begin
    charging  = item.charge_status inside {ST_CHARGING, ST_FULL};
    check_v   = charging || (item.charge_status == ST_NOT_CHARGING);
    sample    = in_fire && (item.operation == OP_SAMPLE) && !item.skip;
    if (item.voltage_mv > ov_mv_r) begin
      run_calc = (run_r == RUN_LIMIT) ? run_r : run_r + 8'd1;
    end else begin
      run_calc = '0;
    end
    trip      = check_v && (run_calc >= ov_samples_r) && !ovp_flag_r;
    full_fail = !charging && (item.gauge_fail inside {GF_FULL_FAIL, GF_BOTH_FAIL});
    aged_fail = !charging && (item.gauge_fail == GF_AGED_FAIL);
    skipped_s = full_fail || aged_fail;
    heat      = charging && ($signed(item.conn_temp) > $signed(heat_limit_r)) && !heat_flag_r;
    cap_full  = item.full_capacity;
  end

  always_comb begin
    run_nxt       = run_r;
    ovp_flag_nxt  = ovp_flag_r;
    heat_flag_nxt = heat_flag_r;
    nominal_nxt   = nominal_r;
    for (int i = 0; i < 4; i++) begin
      cap_nxt[i] = cap_r[i];
      cnt_nxt[i] = cnt_r[i];
    end
    if (sample) begin
      if (check_v) begin
        run_nxt = run_calc;
      end
      if (trip) begin
        ovp_flag_nxt         = 1'b1;
        cnt_nxt[CNT_OVP]     = sat_inc(cnt_r[CNT_OVP]);
        cnt_nxt[CNT_OVP_DAY] = sat_inc(cnt_r[CNT_OVP_DAY]);
      end
      if (heat) begin
        heat_flag_nxt         = 1'b1;
        cnt_nxt[CNT_HEAT]     = sat_inc(cnt_r[CNT_HEAT]);
        cnt_nxt[CNT_HEAT_DAY] = sat_inc(cnt_r[CNT_HEAT_DAY]);
      end
      if (!charging && !full_fail) begin
        if (cap_full > cap_r[0]) cap_nxt[0] = cap_full;
        if (cap_full < cap_r[1]) cap_nxt[1] = cap_full;
        if (cap_full > cap_r[2]) cap_nxt[2] = cap_full;
        if (cap_full < cap_r[3]) cap_nxt[3] = cap_full;
        if (item.gauge_fail == GF_GOOD) begin
          nominal_nxt = item.aged_capacity;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_mv_r      <= OV_MV_RESET;
      ov_samples_r <= OV_SAMPLES_RESET;
      heat_limit_r <= HEAT_LIMIT_RESET;
      algo_r       <= ALGO_RESET;
      cap_r[0]     <= '0;
      cap_r[1]     <= CAP_MIN_RESET;
      cap_r[2]     <= '0;
      cap_r[3]     <= CAP_MIN_RESET;
      nominal_r    <= '0;
      run_r        <= '0;
      ovp_flag_r   <= 1'b0;
      heat_flag_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_OV_MV:      ov_mv_r      <= cfg_data[MV_W-1:0];
          REG_OV_SAMPLES: ov_samples_r <= cfg_data[RUN_W-1:0];
          REG_HEAT_LIMIT: heat_limit_r <= cfg_data[TEMP_W-1:0];
          REG_ALGO:       algo_r       <= cfg_data[ALGO_W-1:0];
          default: ;
        endcase
      end
      for (int i = 0; i < 4; i++) begin
        cap_r[i] <= cap_nxt[i];
        cnt_r[i] <= cnt_nxt[i];
      end
      nominal_r   <= nominal_nxt;
      run_r       <= run_nxt;
      ovp_flag_r  <= ovp_flag_nxt;
      heat_flag_r <= heat_flag_nxt;
    end
  end

  always_comb begin
    case (item.stat_index)
      STAT_ALGO:       stat_value = {{(VAL_W-ALGO_W){1'b0}}, algo_r};
      STAT_CAP_MAX:    stat_value = {{(VAL_W-CAP_W){1'b0}}, cap_r[0]};
      STAT_CAP_MIN:    stat_value = {{(VAL_W-CAP_W){1'b0}}, cap_r[1]};
      STAT_CAP_MAX_D:  stat_value = {{(VAL_W-CAP_W){1'b0}}, cap_r[2]};
      STAT_CAP_MIN_D:  stat_value = {{(VAL_W-CAP_W){1'b0}}, cap_r[3]};
      STAT_NOMINAL:    stat_value = {{(VAL_W-CAP_W){1'b0}}, nominal_r};
      STAT_OVP_CNT:    stat_value = {{(VAL_W-CNT_W){1'b0}}, cnt_r[CNT_OVP]};
      STAT_OVP_CNT_D:  stat_value = {{(VAL_W-CNT_W){1'b0}}, cnt_r[CNT_OVP_DAY]};
      STAT_HEAT_CNT:   stat_value = {{(VAL_W-CNT_W){1'b0}}, cnt_r[CNT_HEAT]};
      STAT_HEAT_CNT_D: stat_value = {{(VAL_W-CNT_W){1'b0}}, cnt_r[CNT_HEAT_DAY]};
      STAT_OV_RUN:     stat_value = {{(VAL_W-RUN_W){1'b0}}, run_r};
      STAT_OVP_FLAG:   stat_value = {{(VAL_W-1){1'b0}}, ovp_flag_r};
      STAT_HEAT_FLAG:  stat_value = {{(VAL_W-1){1'b0}}, heat_flag_r};
      default:         stat_value = '0;
    endcase
  end

  always_comb begin
    idx_m1       = item.stat_index - 6'd1;
    job          = '0;
    job.is_read  = (item.operation == OP_READ);
    job.rd_temp  = job.is_read && (item.stat_index >= STAT_TEMP_FIRST)
                   && (item.stat_index <= STAT_TEMP_LAST);
    job.rd_row   = idx_m1[SUB_W+ROW_AW-1:SUB_W];
    job.rd_sub   = idx_m1[SUB_W-1:0];
    job.temps[0] = item.battery_temp;
    job.temps[1] = item.charger_temp;
    job.temps[2] = item.wireless_temp;
    job.temps[3] = item.conn_temp;
    job.res.ovp_latched = ovp_flag_r;
    if (job.is_read) begin
      job.res.read_value = stat_value;
    end else if (item.skip) begin
      job.res.sample_skipped = 1'b1;
    end else begin
      job.grp_en              = {charging, charging, !skipped_s, !skipped_s};
      job.res.ovp_tripped     = trip;
      job.res.ovp_latched     = ovp_flag_r || trip;
      job.res.overheat_counted = heat;
      job.res.sample_skipped  = skipped_s;
    end
  end
endmodule

### rtl/core/cstm_temp_pipe.sv
// Temperature extreme rows: row sequencer, RAM read-modify-write and forwarding.
module cstm_temp_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  cstm_pkg::job_t      job,
  output logic                free,
  output logic                push,
  output cstm_pkg::out_item_t push_item
);
  import cstm_pkg::*;

  logic              a_busy_r, a_busy_nxt;
  job_t              a_job_r;
  logic [ROW_AW-1:0] a_row_r;
  logic              a_last;

  logic              b_valid_r;
  logic              b_last_r;
  logic [ROW_AW-1:0] b_row_r;
  job_t              b_job_r;

  logic              fwd_en_r;
  logic [ROW_AW-1:0] fwd_row_r;
  temp_row_t         fwd_data_r;
  logic [ROW_N-1:0]  row_valid_r;

  temp_row_t         rdata, cur_row, new_row;
  logic              we;
  temp_t             tv, old_max, old_min, sel;

  cstm_ram #(.WIDTH($bits(temp_row_t)), .DEPTH(ROW_N)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (b_row_r),
    .wdata (new_row),
    .raddr (a_row_r),
    .rdata (rdata)
  );

  assign a_last     = a_job_r.is_read || (a_row_r == ROW_AW'(ROW_N - 1));
  assign free       = !a_busy_r || a_last;
  assign a_busy_nxt = in_fire || (a_busy_r && !a_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_busy_r    <= 1'b0;
      b_valid_r   <= 1'b0;
      fwd_en_r    <= 1'b0;
      row_valid_r <= '0;
    end else begin
      a_busy_r  <= a_busy_nxt;
      b_valid_r <= a_busy_r;
      fwd_en_r  <= we;
      if (we) begin
        row_valid_r[b_row_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_job_r <= job;
      a_row_r <= job.is_read ? job.rd_row : '0;
    end else if (a_busy_r && !a_last) begin
      a_row_r <= a_row_r + 1'b1;
    end
    b_row_r    <= a_row_r;
    b_last_r   <= a_last;
    b_job_r    <= a_job_r;
    fwd_row_r  <= b_row_r;
    fwd_data_r <= new_row;
  end

  always_comb begin
    if (fwd_en_r && (fwd_row_r == b_row_r)) begin
      cur_row = fwd_data_r;
    end else if (row_valid_r[b_row_r]) begin
      cur_row = rdata;
    end else begin
      cur_row = reset_row();
    end
    new_row = cur_row;
    for (int s = 0; s < SENS_N; s++) begin
      tv      = b_job_r.temps[s];
      old_max = cur_row[2*s];
      old_min = cur_row[2*s+1];
      if (tv > old_max) new_row[2*s] = tv;
      if (tv < old_min) new_row[2*s+1] = tv;
    end
    we = b_valid_r && !b_job_r.is_read && b_job_r.grp_en[b_row_r];
  end

  always_comb begin
    sel       = cur_row[b_job_r.rd_sub];
    push      = b_valid_r && b_last_r;
    push_item = b_job_r.res;
    if (b_job_r.rd_temp) begin
      push_item.read_value = {{(VAL_W-TEMP_W){sel[TEMP_W-1]}}, sel};
    end
  end
endmodule

### rtl/core/cstm_out_queue.sv
// Small result queue between the row pipeline and the output channel.
module cstm_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cstm_pkg::out_item_t push_item,
  input  logic                pop,
  output logic                out_valid,
  output cstm_pkg::out_item_t out_item
);
  import cstm_pkg::*;

  out_item_t         slot_r [OUTQ_DEPTH];
  logic [QAW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PEND_W-1:0] count_r;

  assign out_valid = (count_r != '0);
  assign out_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + PEND_W'(push) - PEND_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end
endmodule

### rtl/core/charging_statistics_monitor.sv
// Charging statistics monitor top level.
// Results pass the row stage, the RAM read stage and the result queue, in that order.
// A sample makes one pass per temperature group row through the single RAM port first;
// read items one per cycle when no sample holds the port, up to 4 results outstanding.
// Reset: registers take their defaults at once; RAM rows are marked invalid and read as
// reset extremes until first written, so there is no clearing pass.
module charging_statistics_monitor (
  input  logic   clk,
  input  logic   rst_n,
  cstm_in_if.sink    in_chan,
  cstm_out_if.source out_chan,
  cstm_cfg_if.sink   cfg_chan
);
  import cstm_pkg::*;

  in_item_t          item;
  job_t              job;
  out_item_t         push_item, out_item;
  logic              in_fire, out_fire, cfg_fire, free, push;
  logic [PEND_W-1:0] pending_r;

  assign item.operation     = in_chan.operation;
  assign item.skip          = in_chan.skip;
  assign item.charge_status = in_chan.charge_status;
  assign item.voltage_mv    = in_chan.voltage_mv;
  assign item.battery_temp  = in_chan.battery_temp;
  assign item.charger_temp  = in_chan.charger_temp;
  assign item.wireless_temp = in_chan.wireless_temp;
  assign item.conn_temp     = in_chan.conn_temp;
  assign item.full_capacity = in_chan.full_capacity;
  assign item.aged_capacity = in_chan.aged_capacity;
  assign item.gauge_fail    = in_chan.gauge_fail;
  assign item.stat_index    = in_chan.stat_index;

  assign in_chan.ready  = free && (pending_r < PEND_W'(OUTQ_DEPTH));
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_fire       = out_chan.valid && out_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign cfg_fire       = cfg_chan.valid && cfg_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + PEND_W'(in_fire) - PEND_W'(out_fire);
    end
  end

  cstm_scalars u_scalars (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .item     (item),
    .cfg_we   (cfg_fire),
    .cfg_idx  (cfg_chan.reg_index),
    .cfg_data (cfg_chan.wdata),
    .job      (job)
  );

  cstm_temp_pipe u_temp_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .job       (job),
    .free      (free),
    .push      (push),
    .push_item (push_item)
  );

  cstm_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (out_fire),
    .out_valid (out_chan.valid),
    .out_item  (out_item)
  );

  assign out_chan.read_value       = out_item.read_value;
  assign out_chan.ovp_tripped      = out_item.ovp_tripped;
  assign out_chan.ovp_latched      = out_item.ovp_latched;
  assign out_chan.overheat_counted = out_item.overheat_counted;
  assign out_chan.sample_skipped   = out_item.sample_skipped;
endmodule

### sim/testbench.sv
// Self-checking testbench for the charging statistics monitor: directed and random transfers.
module testbench;
  import cstm_pkg::*;

  localparam int GRP_ALL     = 0;
  localparam int GRP_ALL_DAY = 1;
  localparam int GRP_CHG     = 2;
  localparam int GRP_CHG_DAY = 3;

  localparam int SENS_BATT = 0;
  localparam int SENS_CHGR = 1;
  localparam int SENS_WLS  = 2;
  localparam int SENS_CONN = 3;

  localparam int CAP_MAX_ALL = 0;
  localparam int CAP_MIN_ALL = 1;
  localparam int CAP_MAX_DAY = 2;
  localparam int CAP_MIN_DAY = 3;

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_N       = 4;
  localparam int SOAK_PHASE    = 3;
  localparam int PHASE_ITEMS   = 100;
  localparam int SOAK_ITEMS    = 300;

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;

  cstm_in_if  in_chan ();
  cstm_out_if out_chan ();
  cstm_cfg_if cfg_chan ();

  charging_statistics_monitor uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  class stats_scoreboard;
    logic [MV_W-1:0]   ov_mv;
    logic [RUN_W-1:0]  ov_samples;
    temp_t             heat_limit;
    logic [ALGO_W-1:0] algo;
    temp_t             temps [32];
    logic [CAP_W-1:0]  caps [4];
    logic [CAP_W-1:0]  nominal;
    logic [RUN_W-1:0]  ov_run;
    bit                ovp;
    bit                heat;
    logic [CNT_W-1:0]  counters [4];
    out_item_t         awaited [$];
    int                errors;

    function new();
      ov_mv      = OV_MV_RESET;
      ov_samples = OV_SAMPLES_RESET;
      heat_limit = HEAT_LIMIT_RESET;
      algo       = ALGO_RESET;
      foreach (temps[i]) temps[i] = (i % 2 == 1) ? TEMP_MIN_RESET : TEMP_MAX_RESET;
      caps     = '{16'h0000, CAP_MIN_RESET, 16'h0000, CAP_MIN_RESET};
      nominal  = '0;
      ov_run   = '0;
      ovp      = 1'b0;
      heat     = 1'b0;
      counters = '{default: '0};
      errors   = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OV_MV:      ov_mv = data[MV_W-1:0];
        REG_OV_SAMPLES: ov_samples = data[RUN_W-1:0];
        REG_HEAT_LIMIT: heat_limit = data[TEMP_W-1:0];
        REG_ALGO:       algo = data[ALGO_W-1:0];
        default: ;
      endcase
    endfunction

    function void bump(int k);
      if (counters[k] != CNT_LIMIT) counters[k] = counters[k] + 1'b1;
    endfunction

    function void track(int grp, temp_t t [SENS_N]);
      int b;
      for (int s = 0; s < SENS_N; s++) begin
        b = grp * 8 + s * 2;
        if (t[s] > temps[b]) temps[b] = t[s];
        if (t[s] < temps[b + 1]) temps[b + 1] = t[s];
      end
    endfunction

    function bit check_voltage(logic [MV_W-1:0] mv);
      if (mv > ov_mv) begin
        if (ov_run != RUN_LIMIT) ov_run = ov_run + 1'b1;
      end else begin
        ov_run = '0;
      end
      if (ov_run >= ov_samples && !ovp) begin
        bump(CNT_OVP);
        bump(CNT_OVP_DAY);
        ovp = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic signed [VAL_W-1:0] stat_value(logic [IDX_W-1:0] idx);
      logic signed [VAL_W-1:0] v;
      v = '0;
      if (idx == STAT_ALGO) v = algo;
      else if (idx <= STAT_TEMP_LAST) v = temps[idx - STAT_TEMP_FIRST];
      else if (idx <= STAT_CAP_MIN_D) v = caps[idx - STAT_CAP_MAX];
      else if (idx == STAT_NOMINAL) v = nominal;
      else if (idx <= STAT_HEAT_CNT_D) v = counters[idx - STAT_OVP_CNT];
      else if (idx == STAT_OV_RUN) v = ov_run;
      else if (idx == STAT_OVP_FLAG) v = ovp;
      else if (idx == STAT_HEAT_FLAG) v = heat;
      return v;
    endfunction

    // accepted input transfer: advance the statistics and queue the expected result
    function void note_sample(in_item_t it);
      out_item_t r;
      temp_t     t [SENS_N];
      t[SENS_BATT] = it.battery_temp;
      t[SENS_CHGR] = it.charger_temp;
      t[SENS_WLS]  = it.wireless_temp;
      t[SENS_CONN] = it.conn_temp;
      r = '0;
      if (it.operation == OP_READ) begin
        r.read_value = stat_value(it.stat_index);
      end else if (it.skip) begin
        r.sample_skipped = 1'b1;
      end else begin
        if (it.charge_status == ST_CHARGING || it.charge_status == ST_FULL) begin
          r.ovp_tripped = check_voltage(it.voltage_mv);
          track(GRP_CHG, t);
          track(GRP_CHG_DAY, t);
          if (t[SENS_CONN] > heat_limit && !heat) begin
            bump(CNT_HEAT);
            bump(CNT_HEAT_DAY);
            heat = 1'b1;
            r.overheat_counted = 1'b1;
          end
        end else begin
          if (it.charge_status == ST_NOT_CHARGING) r.ovp_tripped = check_voltage(it.voltage_mv);
          if (it.gauge_fail == GF_FULL_FAIL || it.gauge_fail == GF_BOTH_FAIL) begin
            r.sample_skipped = 1'b1;
          end else begin
            if (it.full_capacity > caps[CAP_MAX_ALL]) caps[CAP_MAX_ALL] = it.full_capacity;
            if (it.full_capacity < caps[CAP_MIN_ALL]) caps[CAP_MIN_ALL] = it.full_capacity;
            if (it.full_capacity > caps[CAP_MAX_DAY]) caps[CAP_MAX_DAY] = it.full_capacity;
            if (it.full_capacity < caps[CAP_MIN_DAY]) caps[CAP_MIN_DAY] = it.full_capacity;
            if (it.gauge_fail == GF_AGED_FAIL) r.sample_skipped = 1'b1;
            else nominal = it.aged_capacity;
          end
        end
        if (!r.sample_skipped) begin
          track(GRP_ALL, t);
          track(GRP_ALL_DAY, t);
        end
      end
      r.ovp_latched = ovp;
      awaited.push_back(r);
    endfunction

    function void compare(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h got %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result transfer with nothing expected, got %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare("read_value", want.read_value, got.read_value);
      compare("ovp_tripped", want.ovp_tripped, got.ovp_tripped);
      compare("ovp_latched", want.ovp_latched, got.ovp_latched);
      compare("overheat_counted", want.overheat_counted, got.overheat_counted);
      compare("sample_skipped", want.sample_skipped, got.sample_skipped);
    endfunction
  endclass

  stats_scoreboard sb = new();

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin : watch
    in_item_t  seen;
    out_item_t got;
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) sb.write_register(cfg_chan.reg_index, cfg_chan.wdata);
      if (in_chan.valid && in_chan.ready) begin
        seen.operation     = in_chan.operation;
        seen.skip          = in_chan.skip;
        seen.charge_status = in_chan.charge_status;
        seen.voltage_mv    = in_chan.voltage_mv;
        seen.battery_temp  = in_chan.battery_temp;
        seen.charger_temp  = in_chan.charger_temp;
        seen.wireless_temp = in_chan.wireless_temp;
        seen.conn_temp     = in_chan.conn_temp;
        seen.full_capacity = in_chan.full_capacity;
        seen.aged_capacity = in_chan.aged_capacity;
        seen.gauge_fail    = in_chan.gauge_fail;
        seen.stat_index    = in_chan.stat_index;
        sb.note_sample(seen);
      end
      if (out_chan.valid && out_chan.ready) begin
        got.read_value       = out_chan.read_value;
        got.ovp_tripped      = out_chan.ovp_tripped;
        got.ovp_latched      = out_chan.ovp_latched;
        got.overheat_counted = out_chan.overheat_counted;
        got.sample_skipped   = out_chan.sample_skipped;
        sb.check_result(got);
      end
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.operation     <= it.operation;
    in_chan.skip          <= it.skip;
    in_chan.charge_status <= it.charge_status;
    in_chan.voltage_mv    <= it.voltage_mv;
    in_chan.battery_temp  <= it.battery_temp;
    in_chan.charger_temp  <= it.charger_temp;
    in_chan.wireless_temp <= it.wireless_temp;
    in_chan.conn_temp     <= it.conn_temp;
    in_chan.full_capacity <= it.full_capacity;
    in_chan.aged_capacity <= it.aged_capacity;
    in_chan.gauge_fail    <= it.gauge_fail;
    in_chan.stat_index    <= it.stat_index;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.reg_index <= idx;
    cfg_chan.wdata     <= data;
    do @(posedge clk); while (!cfg_chan.ready);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t sample_item(logic [1:0] status, logic [MV_W-1:0] mv,
                                           temp_t bt, temp_t ct, temp_t wt, temp_t ut,
                                           logic [CAP_W-1:0] fc, logic [CAP_W-1:0] ac,
                                           logic [1:0] gf);
    in_item_t it;
    it = '0;
    it.operation     = OP_SAMPLE;
    it.charge_status = status;
    it.voltage_mv    = mv;
    it.battery_temp  = bt;
    it.charger_temp  = ct;
    it.wireless_temp = wt;
    it.conn_temp     = ut;
    it.full_capacity = fc;
    it.aged_capacity = ac;
    it.gauge_fail    = gf;
    return it;
  endfunction

  function automatic in_item_t read_item(logic [IDX_W-1:0] idx);
    in_item_t it;
    it = '0;
    it.operation  = OP_READ;
    it.stat_index = idx;
    return it;
  endfunction

  function automatic in_item_t random_item(bit soak);
    in_item_t     it;
    logic [127:0] bits;
    int           v;
    bits = {$urandom, $urandom, $urandom, $urandom};
    it = bits[$bits(in_item_t)-1:0];
    it.operation = ($urandom_range(0, 99) < (soak ? 5 : 30)) ? OP_READ : OP_SAMPLE;
    it.skip = ($urandom_range(0, 99) < (soak ? 2 : 8));
    if (soak) begin
      it.charge_status = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 0) it.stat_index = STAT_OV_RUN;
    end
    case ($urandom_range(0, 3))
      0: v = int'(sb.ov_mv) + int'($urandom_range(0, 4)) - 2;
      1: v = $urandom_range(0, 1) ? 65535 : 0;
      default: v = int'(it.voltage_mv);
    endcase
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    if (soak) v = $urandom_range(1, 65535);
    it.voltage_mv = v[MV_W-1:0];
    if ($urandom_range(0, 3) == 0) it.conn_temp = temp_t'(sb.heat_limit + $urandom_range(0, 2) - 1);
    if ($urandom_range(0, 7) == 0) it.full_capacity = $urandom_range(0, 1) ? CAP_MIN_RESET : '0;
    if ($urandom_range(0, 99) < 60) it.gauge_fail = GF_GOOD;
    return it;
  endfunction

  initial begin
    in_item_t          directed [$];
    in_item_t          it;
    logic [MV_W-1:0]   mv;
    logic [RUN_W-1:0]  samples;
    temp_t             limit;
    logic [ALGO_W-1:0] algo;
    int                count;

    rst_n                 = 1'b0;
    in_idle_pct           = 35;
    out_idle_pct          = 78;
    in_chan.valid         = 1'b0;
    in_chan.operation     = OP_SAMPLE;
    in_chan.skip          = 1'b0;
    in_chan.charge_status = ST_CHARGING;
    in_chan.voltage_mv    = '0;
    in_chan.battery_temp  = '0;
    in_chan.charger_temp  = '0;
    in_chan.wireless_temp = '0;
    in_chan.conn_temp     = '0;
    in_chan.full_capacity = '0;
    in_chan.aged_capacity = '0;
    in_chan.gauge_fail    = GF_GOOD;
    in_chan.stat_index    = '0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.reg_index    = REG_OV_MV;
    cfg_chan.wdata        = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, skip mode, debounce, gauge failures, overheat once
    directed.push_back(read_item(STAT_TEMP_FIRST + 1'b1));
    directed.push_back(read_item(STAT_CAP_MIN_D));
    it = sample_item(ST_CHARGING, 16'hFFFF, 12'sh7FF, 12'sh800, 12'sh7FF, 12'sh800,
                     16'hFFFF, 16'hFFFF, GF_BOTH_FAIL);
    it.skip = 1'b1;
    directed.push_back(it);
    directed.push_back(sample_item(ST_CHARGING, OV_MV_RESET + 1'b1, 12'sd250, 12'sd300,
                                   12'sd280, HEAT_LIMIT_RESET, 16'hFFFF, 16'hFFFF,
                                   GF_BOTH_FAIL));
    directed.push_back(sample_item(ST_FULL, OV_MV_RESET, -12'sd50, -12'sd40, -12'sd30,
                                   -12'sd20, 16'h0000, 16'h0000, GF_FULL_FAIL));
    directed.push_back(sample_item(ST_NOT_CHARGING, 16'hFFFF, 12'sh7FF, 12'sh7FF, 12'sh7FF,
                                   12'sh7FF, 16'hFFFF, 16'h0000, GF_GOOD));
    directed.push_back(sample_item(ST_DISCHARGING, 16'hFFFF, 12'sh800, 12'sh800, 12'sh800,
                                   12'sh800, 16'h0000, 16'hFFFF, GF_FULL_FAIL));
    directed.push_back(sample_item(ST_NOT_CHARGING, 16'hFFFF, 12'sh800, 12'sh800, 12'sh800,
                                   12'sh800, 16'h0000, 16'hFFFF, GF_BOTH_FAIL));
    directed.push_back(sample_item(ST_NOT_CHARGING, 16'h0000, 12'sh800, 12'sh800, 12'sh800,
                                   12'sh800, 16'h0000, 16'h1234, GF_AGED_FAIL));
    directed.push_back(sample_item(ST_DISCHARGING, 16'h0000, 12'sh800, 12'sh800, 12'sh800,
                                   12'sh800, 16'h8000, 16'h7FFF, GF_GOOD));
    directed.push_back(sample_item(ST_DISCHARGING, 16'hFFFF, 12'sd0, 12'sd0, 12'sd0,
                                   HEAT_LIMIT_RESET + 12'sd1, 16'h4000, 16'h5555, GF_GOOD));
    directed.push_back(sample_item(ST_CHARGING, OV_MV_RESET, 12'sd10, 12'sd20, 12'sd30,
                                   HEAT_LIMIT_RESET + 12'sd1, 16'h0000, 16'h0000, GF_GOOD));
    directed.push_back(sample_item(ST_FULL, OV_MV_RESET, 12'sd10, 12'sd20, 12'sd30,
                                   12'sh7FF, 16'h0000, 16'h0000, GF_GOOD));
    directed.push_back(read_item(STAT_CAP_MIN));
    directed.push_back(read_item(STAT_NOMINAL));
    directed.push_back(read_item(STAT_OVP_CNT));
    directed.push_back(read_item(STAT_HEAT_CNT_D));
    directed.push_back(read_item(STAT_OV_RUN));
    directed.push_back(read_item(STAT_OVP_FLAG));
    directed.push_back(read_item(STAT_HEAT_FLAG));
    directed.push_back(read_item(STAT_HEAT_FLAG + 1'b1));
    directed.push_back(read_item({IDX_W{1'b1}}));
    foreach (directed[i]) send_item(directed[i]);
    in_chan.valid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < PHASE_N; ph++) begin
      case (ph)
        0: begin
          mv      = 16'($urandom_range(4000, 4800));
          samples = 8'd3;
          limit   = temp_t'($urandom_range(0, 1000));
          algo    = 8'($urandom);
        end
        1: begin
          mv      = 16'hFFFF;
          samples = 8'hFF;
          limit   = 12'sh800;
          algo    = 8'hFF;
        end
        2: begin
          mv      = 16'($urandom);
          samples = 8'd1;
          limit   = 12'sh7FF;
          algo    = 8'($urandom);
        end
        default: begin
          mv      = 16'h0000;
          samples = 8'd0;
          limit   = temp_t'($urandom);
          algo    = 8'h00;
        end
      endcase
      cfg_write(REG_OV_MV, mv);
      cfg_write(REG_OV_SAMPLES, {8'($urandom), samples});
      cfg_write(REG_HEAT_LIMIT, {4'($urandom), limit});
      cfg_write(REG_ALGO, {8'($urandom), algo});
      cfg_write(4'($urandom_range(REG_ALGO + 1, 15)), 16'($urandom));
      cfg_chan.valid <= 1'b0;

      in_idle_pct  = (ph < 2) ? 35 : (ph == 2) ? 78 : 0;
      out_idle_pct = (ph < 2) ? 78 : (ph == 2) ? 35 : 0;
      count = (ph == SOAK_PHASE) ? SOAK_ITEMS : PHASE_ITEMS;
      repeat (count) send_item(random_item(ph == SOAK_PHASE));
      in_chan.valid <= 1'b0;
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
